// ===== rtl/core/lbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the 3x3 local binary pattern block.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PIX_W        = 8;
   localparam int DIM_W        = 12;   // width/height register fields
   localparam int ROW_W        = 11;   // row counter, heights up to 2048
   localparam int POS_W        = 11;   // out_x / out_y
   localparam int SUM_W        = 9;    // centre + threshold
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int MAX_WIDTH_DEF = 2048;

   localparam logic [DIM_W-1:0] DIM_MIN      = 12'd3;
   localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 12'd2048;

   localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
   localparam logic [PIX_W-1:0] THRESH_RST = 8'd4;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_THRESH = 2'd2,
      REG_INVERT = 2'd3
   } lbp_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } lbp_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] code;
      logic [POS_W-1:0] out_x;
      logic [POS_W-1:0] out_y;
      logic             frame_last;
   } lbp_rsp_type;

   // one window column, top to bottom
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } lbp_col_type;

endpackage

// ===== rtl/core/lbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];   // old data on a same-address write
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lbp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_cell
// One window column: holds three pixels, takes its neighbour's column on a
// shift and compares the incoming pixels against centre plus threshold.
// ----------------------------------------------------------------------------
module lbp_cell (
   input  logic                              clock,
   input  logic                              shift,
   input  lbp_pkg::lbp_col_type              col_in,
   input  logic [lbp_pkg::SUM_W-1:0]         sum,
   output lbp_pkg::lbp_col_type              col,
   output logic [2:0]                        ge
);
   import lbp_pkg::*;

   lbp_col_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   // {top, mid, bot} against the 9-bit sum; a sum above 255 never matches
   assign ge[2] = {1'b0, col_in.top} >= sum;
   assign ge[1] = {1'b0, col_in.mid} >= sum;
   assign ge[0] = {1'b0, col_in.bot} >= sum;

   assign col = col_ff;

endmodule

// ===== rtl/core/local_binary_pattern_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3
// 8-neighbour LBP over a raster pixel stream, three-column cell chain.
// ----------------------------------------------------------------------------
// Path: a pixel request is registered in stage 1, and its code then in the
//   result register, which drives rsp_data.
// Throughput: one pixel per cycle, set by the single line store read port
//   and the one-column-per-cycle chain shift, while no code stalls stage 1.
// Reset (synchronous, active high): counters and handshake state cleared,
//   registers to 640 / 480 / 4 / 0. Line stores are not cleared and need
//   no clearing pass; the window is loaded before it is ever used.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3 #(
   parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel requests
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lbp_pkg::lbp_req_type               req_data,
   // codes
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lbp_pkg::lbp_rsp_type               rsp_data,
   // APB-style register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lbp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lbp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import lbp_pkg::*;

   // column counter covers 0..MAX_WIDTH-1; WW also holds MAX_WIDTH itself
   // and the 12-bit width register
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
   localparam int LW = 2 * PIX_W;   // line store word: {upper, middle}

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [PIX_W-1:0] thresh_ff;
   logic             invert_ff;
   logic             csr_write;
   lbp_reg_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = lbp_reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thresh_ff <= THRESH_RST;
         invert_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            REG_THRESH: thresh_ff <= pwdata[PIX_W-1:0];
            REG_INVERT: invert_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_THRESH: prdata = CSR_DATA_W'(thresh_ff);
         REG_INVERT: prdata = CSR_DATA_W'(invert_ff);
         default:    prdata = '0;
      endcase
   end

   // clamped geometry in use
   logic [WW-1:0]    w_eff;
   logic [DIM_W-1:0] h_eff;

   always_comb begin
      if (width_ff < DIM_MIN) begin
         w_eff = WW'(DIM_MIN);
      end else if (WW'(width_ff) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff < DIM_MIN) begin
         h_eff = DIM_MIN;
      end else if (height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end
   end

   // ------------------------------------------------------------------
   // Handshake: stage 1 (line store read) then the result register
   // ------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_produce_ff, s1_last_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [CW-1:0]    s1_addr_ff;
   logic [POS_W-1:0] s1_x_ff, s1_y_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   lbp_rsp_type rsp_data_ff;
   logic        out_free, s1_move, req_accept;

   // a pixel that yields no code passes stage 1 even while a code waits
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && (!s1_produce_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Position counters, evaluated for the incoming pixel
   // ------------------------------------------------------------------
   logic [CW-1:0]    col_ff, col_in, x0;
   logic [ROW_W-1:0] row_ff, row_in, y0;
   logic [WW-1:0]    x_ext, x_inc, x_sub;
   logic [DIM_W-1:0] y_ext, y_inc;
   logic             col_wrap, row_wrap, produce, last;
   logic [PIX_W-1:0] pix_map;

   always_comb begin
      // frame start resyncs before the flagged pixel is placed
      x0    = req_data.frame_start ? '0 : col_ff;
      y0    = req_data.frame_start ? '0 : row_ff;
      x_ext = WW'(x0);
      y_ext = DIM_W'(y0);
      x_inc = x_ext + WW'(1);
      y_inc = y_ext + DIM_W'(1);
      x_sub = x_ext - WW'(2);
      col_wrap = x_inc >= w_eff;
      row_wrap = y_inc >= h_eff;
      col_in = col_wrap ? '0 : x_inc[CW-1:0];
      if (col_wrap) begin
         row_in = row_wrap ? '0 : y_inc[ROW_W-1:0];
      end else begin
         row_in = y0;
      end
      produce = (x_ext >= WW'(2)) && (y_ext >= DIM_W'(2)) &&
                (x_ext < w_eff) && (y_ext < h_eff);
      last    = (x_ext == w_eff - WW'(1)) && (y_ext == h_eff - DIM_W'(1));
      // invert: p -> min(255, 256 - p)
      if (!invert_ff) begin
         pix_map = req_data.pixel;
      end else if (req_data.pixel == '0) begin
         pix_map = '1;
      end else begin
         pix_map = ~req_data.pixel + PIX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 registers
   // ------------------------------------------------------------------
   assign s1_valid_in = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_pixel_ff   <= pix_map;
         s1_addr_ff    <= x0;
         s1_produce_ff <= produce;
         s1_last_ff    <= last;
         s1_x_ff       <= x_sub[POS_W-1:0];
         s1_y_ff       <= POS_W'(y0 - ROW_W'(2));
      end
   end

   // ------------------------------------------------------------------
   // Line stores, one RAM word {upper, middle} per column
   // ------------------------------------------------------------------
   logic [LW-1:0]  ram_rd, line_rd, line_wr;
   logic           lw_valid_ff;
   logic [CW-1:0]  lw_addr_ff;
   logic [LW-1:0]  lw_data_ff;

   lbp_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr),
      .rd_en   (req_accept),
      .rd_addr (x0),
      .rd_data (ram_rd)
   );

   // last write bypass: covers a read at the edge of a same-column write
   assign line_rd = (lw_valid_ff && lw_addr_ff == s1_addr_ff) ? lw_data_ff : ram_rd;
   assign line_wr = {line_rd[PIX_W-1:0], s1_pixel_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (s1_move) begin
         lw_valid_ff <= 1'b1;
      end
      if (s1_move) begin
         lw_addr_ff <= s1_addr_ff;
         lw_data_ff <= line_wr;
      end
   end

   // ------------------------------------------------------------------
   // Cell chain: right column takes the new column, others shift left
   // ------------------------------------------------------------------
   lbp_col_type      new_col, col_left, col_centre, col_right;
   logic [2:0]       ge_left, ge_centre, ge_right;
   logic [SUM_W-1:0] sum;
   logic [PIX_W-1:0] code;

   assign new_col.top = line_rd[LW-1:PIX_W];
   assign new_col.mid = line_rd[PIX_W-1:0];
   assign new_col.bot = s1_pixel_ff;

   // centre after the shift is the current right column's middle
   assign sum = SUM_W'(col_right.mid) + SUM_W'(thresh_ff);

   lbp_cell u_cell_right (
      .clock  (clock),
      .shift  (s1_move),
      .col_in (new_col),
      .sum    (sum),
      .col    (col_right),
      .ge     (ge_right)
   );

   lbp_cell u_cell_centre (
      .clock  (clock),
      .shift  (s1_move),
      .col_in (col_right),
      .sum    (sum),
      .col    (col_centre),
      .ge     (ge_centre)
   );

   lbp_cell u_cell_left (
      .clock  (clock),
      .shift  (s1_move),
      .col_in (col_centre),
      .sum    (sum),
      .col    (col_left),
      .ge     (ge_left)
   );

   // clockwise from top-left (bit 7) round to left (bit 0); ge = {top,mid,bot}
   assign code = {ge_left[2], ge_centre[2], ge_right[2], ge_right[1],
                  ge_right[0], ge_centre[0], ge_left[0], ge_left[1]};

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_comb begin
      if (s1_move && s1_produce_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_move && s1_produce_ff) begin
         rsp_data_ff.code       <= code;
         rsp_data_ff.out_x      <= s1_x_ff;
         rsp_data_ff.out_y      <= s1_y_ff;
         rsp_data_ff.frame_last <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // col_left feeds nothing; the left comparators see col_centre on col_in
   logic unused_left;
   assign unused_left = ^col_left;

endmodule
